### design/sst_pkg.sv
// Shared types, constants and helpers for the sorted set table.
`timescale 1ns / 1ps

package sst_pkg;

	localparam int CAPACITY = 8;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int VAL_W = 32;
	localparam int POS_W = 4;
	localparam int OCC_W = 4;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_SEARCH = 2'd2,
		KIND_SHOW   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_ZERO     = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_DUP      = 3'd3,
		STAT_EMPTY    = 3'd4,
		STAT_NOTFOUND = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_PUT,
		ST_SHOW_RD,
		ST_SHOW_LD,
		ST_DONE
	} state_t;

	typedef struct packed {
		status_t           status;
		logic [POS_W-1:0]  position;
		logic [VAL_W-1:0]  element;
		logic [OCC_W-1:0]  occupancy;
		logic              last;
	} res_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [VAL_W-1:0]  data;
	} ram_wr_t;

	function automatic res_t make_res(status_t st, logic [CNT_W-1:0] pos,
			logic [VAL_W-1:0] elem, logic [CNT_W-1:0] occ, logic lst);
		res_t r;
		r.status    = st;
		r.position  = POS_W'(pos);
		r.element   = elem;
		r.occupancy = OCC_W'(occ);
		r.last      = lst;
		return r;
	endfunction

endpackage

### design/sst_ram.sv
// Generic single-write, single-read memory with a registered read port.
`timescale 1ns / 1ps

module sst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/sst_ctrl.sv
// Sequencer that scans, shifts and streams the table entries held in memory.
`timescale 1ns / 1ps

module sst_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   in_kind,
	input  logic [sst_pkg::VAL_W-1:0]    in_value,
	output logic                         res_valid,
	input  logic                         res_ready,
	output sst_pkg::res_t                res,
	output sst_pkg::ram_wr_t             ram_wr,
	output logic [sst_pkg::IDX_W-1:0]    ram_raddr,
	input  logic [sst_pkg::VAL_W-1:0]    ram_rdata
);
	import sst_pkg::*;

	state_t            state_q, state_d;
	kind_t             kind_q, kind_d;
	logic [VAL_W-1:0]  value_q, value_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  i_q, i_d;
	logic [IDX_W-1:0]  pos_q, pos_d;
	res_t              res_q, res_d;

	logic              eq, gt, at_end;
	logic [CNT_W-1:0]  i_inc, i_dec, cnt_inc, cnt_dec;

	assign i_inc   = i_q + CNT_W'(1);
	assign i_dec   = i_q - CNT_W'(1);
	assign cnt_inc = count_q + CNT_W'(1);
	assign cnt_dec = count_q - CNT_W'(1);
	assign eq      = (ram_rdata == value_q);
	assign gt      = ($signed(value_q) < $signed(ram_rdata));
	assign at_end  = (i_inc == count_q);

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q  <= kind_d;
		value_q <= value_d;
		i_q     <= i_d;
		pos_q   <= pos_d;
		res_q   <= res_d;
	end

	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		value_d   = value_q;
		count_d   = count_q;
		i_d       = i_q;
		pos_d     = pos_q;
		res_d     = res_q;
		ram_wr    = '0;
		ram_raddr = i_q[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					kind_d  = kind_t'(in_kind);
					value_d = in_value;
					i_d     = '0;
					pos_d   = '0;
					state_d = ST_DONE;
					unique case (kind_t'(in_kind))
						KIND_ADD: begin
							if (in_value == '0) begin
								res_d = make_res(STAT_ZERO, '0, in_value, count_q, 1'b1);
							end else if (count_q >= CNT_W'(CAPACITY)) begin
								res_d = make_res(STAT_FULL, '0, in_value, count_q, 1'b1);
							end else if (count_q == '0) begin
								state_d = ST_PUT;
							end else begin
								state_d = ST_SCAN_RD;
							end
						end
						KIND_DELETE: begin
							if (count_q == '0) begin
								res_d = make_res(STAT_EMPTY, '0, in_value, '0, 1'b1);
							end else begin
								state_d = ST_SCAN_RD;
							end
						end
						KIND_SEARCH: begin
							if (count_q == '0) begin
								res_d = make_res(STAT_NOTFOUND, '0, in_value, count_q, 1'b1);
							end else begin
								state_d = ST_SCAN_RD;
							end
						end
						KIND_SHOW: begin
							if (count_q == '0) begin
								res_d = make_res(STAT_EMPTY, '0, '0, '0, 1'b1);
							end else begin
								state_d = ST_SHOW_RD;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				unique case (kind_q)
					KIND_ADD: begin
						if (eq) begin
							res_d   = make_res(STAT_DUP, '0, value_q, count_q, 1'b1);
							state_d = ST_DONE;
						end else if (gt) begin
							pos_d   = i_q[IDX_W-1:0];
							i_d     = count_q;
							state_d = ST_SHIFT_RD;
						end else if (at_end) begin
							pos_d   = IDX_W'(count_q);
							state_d = ST_PUT;
						end else begin
							i_d     = i_inc;
							state_d = ST_SCAN_RD;
						end
					end
					KIND_DELETE: begin
						if (eq) begin
							pos_d = i_q[IDX_W-1:0];
							if (at_end) begin
								count_d = cnt_dec;
								res_d   = make_res(STAT_OK, i_q, value_q, cnt_dec, 1'b1);
								state_d = ST_DONE;
							end else begin
								state_d = ST_SHIFT_RD;
							end
						end else if (gt || at_end) begin
							res_d   = make_res(STAT_NOTFOUND, '0, value_q, count_q, 1'b1);
							state_d = ST_DONE;
						end else begin
							i_d     = i_inc;
							state_d = ST_SCAN_RD;
						end
					end
					KIND_SEARCH: begin
						if (eq) begin
							res_d   = make_res(STAT_OK, i_q, value_q, count_q, 1'b1);
							state_d = ST_DONE;
						end else if (gt || at_end) begin
							res_d   = make_res(STAT_NOTFOUND, '0, value_q, count_q, 1'b1);
							state_d = ST_DONE;
						end else begin
							i_d     = i_inc;
							state_d = ST_SCAN_RD;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_SHIFT_RD: begin
				ram_raddr = (kind_q == KIND_ADD) ? i_dec[IDX_W-1:0] : i_inc[IDX_W-1:0];
				state_d   = ST_SHIFT_WR;
			end
			ST_SHIFT_WR: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = i_q[IDX_W-1:0];
				ram_wr.data = ram_rdata;
				if (kind_q == KIND_ADD) begin
					i_d     = i_dec;
					state_d = (i_dec == CNT_W'(pos_q)) ? ST_PUT : ST_SHIFT_RD;
				end else begin
					i_d = i_inc;
					if ((i_inc + CNT_W'(1)) == count_q) begin
						count_d = cnt_dec;
						res_d   = make_res(STAT_OK, CNT_W'(pos_q), value_q, cnt_dec, 1'b1);
						state_d = ST_DONE;
					end else begin
						state_d = ST_SHIFT_RD;
					end
				end
			end
			ST_PUT: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = pos_q;
				ram_wr.data = value_q;
				count_d     = cnt_inc;
				res_d       = make_res(STAT_OK, CNT_W'(pos_q), value_q, cnt_inc, 1'b1);
				state_d     = ST_DONE;
			end
			ST_SHOW_RD: begin
				state_d = ST_SHOW_LD;
			end
			ST_SHOW_LD: begin
				res_d   = make_res(STAT_OK, i_q, ram_rdata, count_q, at_end);
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_ready) begin
					if (kind_q == KIND_SHOW && !res_q.last) begin
						i_d     = i_inc;
						state_d = ST_SHOW_RD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> (count_q == $past(count_q) ||
			count_q == $past(count_q) + CNT_W'(1) || count_q + CNT_W'(1) == $past(count_q)))
		else $error("entry count moved by more than one");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && res_q.last) |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle after final result");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr.en |-> (state_q == ST_SHIFT_WR || state_q == ST_PUT))
		else $error("memory written outside shift or insert");

endmodule

### design/sorted_set_table.sv
// Top level of the sorted set table: memory, sequencer and output register.
//
// A bounded set of distinct nonzero signed values kept in ascending order.
// Input channel (in_valid/in_ready, kind, value) takes one command at a time:
// add, delete, search or show. Output channel (out_valid/out_ready) delivers
// result transfers with status, position, element, occupancy and last.
// Add, delete and search give one transfer; show gives one per stored entry,
// or a single empty result.
// Results decided at once go straight to the done state. Otherwise each
// entry scanned passes a read and a check state, each entry shifted a
// read and a write state, and an insert a write state; show passes a read,
// a load and the done state per entry. The entry memory has a single read port.
// A new command is taken once the previous one has handed its final result
// to the output register, even while that result waits for the receiver.
// When the receiver stalls, the output register holds its result and the
// sequencer waits with the next one. Reset empties the set; the memory
// itself is not cleared, as only entries below the count are ever read.
`timescale 1ns / 1ps

module sorted_set_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    kind,
	input  logic signed [sst_pkg::VAL_W-1:0] value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic [sst_pkg::POS_W-1:0]     position,
	output logic signed [sst_pkg::VAL_W-1:0] element,
	output logic [sst_pkg::OCC_W-1:0]     occupancy,
	output logic                          last
);
	import sst_pkg::*;

	logic              res_valid, res_ready;
	res_t              res;
	ram_wr_t           ram_wr;
	logic [IDX_W-1:0]  ram_raddr;
	logic [VAL_W-1:0]  ram_rdata;
	logic              out_valid_q;
	res_t              out_res_q;

	sst_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_wr.en),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_kind   (kind),
		.in_value  (value),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_wr    (ram_wr),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_res_q.status;
	assign position  = out_res_q.position;
	assign element   = out_res_q.element;
	assign occupancy = out_res_q.occupancy;
	assign last      = out_res_q.last;

endmodule

### verif/sorted_set_table_tb.sv
// Self-checking testbench for the sorted set table with directed, pressure and random tests.
`timescale 1ns / 1ps

module sorted_set_table_tb;
	import sst_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 330;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] kind;
	logic signed [VAL_W-1:0] value;
	logic out_valid;
	logic out_ready;
	logic [2:0] status;
	logic [POS_W-1:0] position;
	logic signed [VAL_W-1:0] element;
	logic [OCC_W-1:0] occupancy;
	logic last;

	logic signed [VAL_W-1:0] shadow_tbl [CAPACITY];
	int shadow_count;
	res_t replies_due [$];
	res_t oldest_reply;

	int error_count;
	int sent_count;
	int checked_count;
	int full_count;
	int kind_count [4];
	bit idle_on;
	int hold_len;
	int hold_seq;

	sorted_set_table u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.position(position),
		.element(element),
		.occupancy(occupancy),
		.last(last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void predict_table_reply(input kind_t k, input logic signed [VAL_W-1:0] v);
		int idx;
		int pos;
		res_t r;
		idx = -1;
		for (int i = 0; i < shadow_count; i++)
			if (idx < 0 && shadow_tbl[i] == v)
				idx = i;
		if (k == KIND_SHOW) begin
			if (shadow_count == 0) begin
				r.status = STAT_EMPTY;
				r.position = '0;
				r.element = '0;
				r.occupancy = '0;
				r.last = 1'b1;
				replies_due.push_back(r);
			end else begin
				for (int i = 0; i < shadow_count; i++) begin
					r.status = STAT_OK;
					r.position = POS_W'(i);
					r.element = shadow_tbl[i];
					r.occupancy = OCC_W'(shadow_count);
					r.last = (i == shadow_count - 1);
					replies_due.push_back(r);
				end
			end
			return;
		end
		r.status = STAT_OK;
		r.position = '0;
		r.element = v;
		r.last = 1'b1;
		case (k)
			KIND_ADD: begin
				if (v == 0)
					r.status = STAT_ZERO;
				else if (shadow_count >= CAPACITY)
					r.status = STAT_FULL;
				else if (idx >= 0)
					r.status = STAT_DUP;
				else begin
					pos = 0;
					for (int i = 0; i < shadow_count; i++)
						if (shadow_tbl[i] < v)
							pos = i + 1;
					for (int i = shadow_count; i > pos; i--)
						shadow_tbl[i] = shadow_tbl[i - 1];
					shadow_tbl[pos] = v;
					shadow_count++;
					if (shadow_count == CAPACITY)
						full_count++;
					r.position = POS_W'(pos);
				end
			end
			KIND_DELETE: begin
				if (shadow_count == 0)
					r.status = STAT_EMPTY;
				else if (idx < 0)
					r.status = STAT_NOTFOUND;
				else begin
					for (int i = idx; i + 1 < shadow_count; i++)
						shadow_tbl[i] = shadow_tbl[i + 1];
					shadow_count--;
					r.position = POS_W'(idx);
				end
			end
			default: begin
				if (idx >= 0)
					r.position = POS_W'(idx);
				else
					r.status = STAT_NOTFOUND;
			end
		endcase
		r.occupancy = OCC_W'(shadow_count);
		replies_due.push_back(r);
	endfunction

	task automatic send_cmd(input kind_t k, input logic signed [VAL_W-1:0] v);
		int gap;
		gap = idle_on ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_table_reply(k, v);
		sent_count++;
		kind_count[k]++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d element %0h",
					$time, status, element);
				error_count++;
			end else begin
				oldest_reply = replies_due.pop_front();
				check_field("status", oldest_reply.status, status);
				check_field("position", oldest_reply.position, position);
				check_field("element", oldest_reply.element, element);
				check_field("occupancy", oldest_reply.occupancy, occupancy);
				check_field("last", oldest_reply.last, last);
				checked_count++;
			end
		end
	end

	initial begin : receiver
		int gap;
		int hold_seen;
		gap = 0;
		hold_seen = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				gap = hold_len;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				gap--;
			end else begin
				out_ready <= 1'b1;
				if (idle_on)
					gap = pick_gap();
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
		$display("sorted_set_table_tb: done, errors");
		$finish;
	end

	task automatic test_empty_table();
		send_cmd(KIND_SHOW, 32'sd0);
		send_cmd(KIND_SEARCH, 32'sd5);
		send_cmd(KIND_DELETE, 32'sd7);
		send_cmd(KIND_ADD, 32'sd0);
	endtask

	task automatic test_fill_and_bounds();
		send_cmd(KIND_ADD, 32'sd100);
		send_cmd(KIND_ADD, 32'sh7FFFFFFF);
		send_cmd(KIND_ADD, -32'sd100);
		send_cmd(KIND_ADD, 32'sh80000000);
		send_cmd(KIND_ADD, 32'sd1);
		send_cmd(KIND_ADD, -32'sd1);
		send_cmd(KIND_ADD, 32'sd50);
		send_cmd(KIND_ADD, 32'sd3);
		send_cmd(KIND_ADD, 32'sd9);
		send_cmd(KIND_ADD, 32'sd0);
		send_cmd(KIND_ADD, 32'sd50);
		send_cmd(KIND_SHOW, 32'sd0);
		send_cmd(KIND_SEARCH, 32'sh80000000);
		send_cmd(KIND_SEARCH, 32'sh7FFFFFFF);
		send_cmd(KIND_DELETE, 32'sd0);
		send_cmd(KIND_DELETE, 32'sd12345);
		send_cmd(KIND_DELETE, 32'sh7FFFFFFF);
		send_cmd(KIND_DELETE, 32'sh80000000);
		send_cmd(KIND_DELETE, 32'sd50);
		send_cmd(KIND_ADD, 32'sd1);
		send_cmd(KIND_SHOW, 32'sd0);
	endtask

	task automatic test_receiver_hold();
		idle_on = 1'b0;
		hold_len = 180;
		hold_seq++;
		for (int i = 0; i < 12; i++)
			send_cmd(kind_t'(i % 4), $urandom_range(1, 20));
		idle_on = 1'b1;
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 6; i++)
			send_cmd(kind_t'($urandom_range(0, 3)), $urandom_range(1, 20));
		wait_drained();
		for (int i = 0; i < 6; i++)
			send_cmd(kind_t'($urandom_range(0, 3)), $urandom_range(1, 20));
	endtask

	task automatic test_random(input int n);
		logic signed [VAL_W-1:0] pool [16];
		logic signed [VAL_W-1:0] v;
		kind_t k;
		int r;
		for (int i = 0; i < 16; i++)
			pool[i] = (i < 6) ? VAL_W'($urandom_range(1, 40)) : VAL_W'($urandom);
		for (int i = 0; i < n; i++) begin
			if (i % 60 == 0)
				idle_on = ((i / 60) % 3 != 1);
			if (i % 40 == 39)
				pool[$urandom_range(0, 15)] = $urandom;
			r = $urandom_range(0, 99);
			if (r < 40)
				k = KIND_ADD;
			else if (r < 65)
				k = KIND_DELETE;
			else if (r < 88)
				k = KIND_SEARCH;
			else
				k = KIND_SHOW;
			r = $urandom_range(0, 99);
			if (r < 80)
				v = pool[$urandom_range(0, 15)];
			else if (r < 85)
				v = '0;
			else
				v = $urandom;
			send_cmd(k, v);
		end
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_ADD;
		value = '0;
		shadow_count = 0;
		error_count = 0;
		sent_count = 0;
		checked_count = 0;
		full_count = 0;
		kind_count = '{default: 0};
		idle_on = 1'b1;
		hold_len = 0;
		hold_seq = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_fill_and_bounds();
		test_receiver_hold();
		test_drain_pause();
		test_random(RANDOM_ITEMS);

		wait_drained();
		repeat (60) @(posedge clk);
		$display("summary: %0d commands (add %0d, delete %0d, search %0d, show %0d), %0d results checked",
			sent_count, kind_count[KIND_ADD], kind_count[KIND_DELETE],
			kind_count[KIND_SEARCH], kind_count[KIND_SHOW], checked_count);
		$display("summary: table filled to capacity %0d times, long receiver stall and input pause included",
			full_count);
		if (error_count == 0)
			$display("sorted_set_table_tb: done, clean");
		else
			$display("sorted_set_table_tb: done, errors");
		$finish;
	end

endmodule
